### rtl/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// Used by every module of the block; depends on nothing else.
package bba_pkg;

	// Sizes of the pool and of the fields.
	localparam int MAX_BLOCKS = 64;
	localparam int ADDR_W = 32;
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = 7;
	localparam int SIZE_W = 16;
	localparam int STATUS_W = 2;
	localparam int REG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes of the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_POOL_BASE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

	// Request kinds after classification by the front end.
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE = 2'd1;
	localparam logic [1:0] CMD_NULL = 2'd2;

	// One classified request as it travels through the queue.
	typedef struct packed {
		logic [1:0] kind;
		logic [ADDR_W-1:0] address;
	} cmd_t;

endpackage

### rtl/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: front end, request queue and search engine.
// Depends on bba_pkg, bba_front, bba_queue and bba_engine.

// Hands out and takes back equal blocks of a pool; each request beat gives one result
// beat. The search engine examines one block per clock and works on one request at a
// time. An allocate scans from block 0 up to the lowest free block, and a free of a
// matching address scans up to that block. A failed search scans every live block,
// where a block_count above 64 counts as 64. A free of the null address, or any
// request while no block is configured, needs no search. A request passes the
// registered front stage and the queue before it reaches the engine. The front end
// and a two-entry queue keep accepting requests while the engine searches, and a
// finished result waits in the output register until taken.
module bitmap_block_allocator (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [bba_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0] cfg_wr_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [bba_pkg::ADDR_W-1:0] s_tdata, // [31:0] address
	input  logic [0:0] s_tuser,                 // [0] action
	output logic m_tvalid,
	input  logic m_tready,
	output logic [bba_pkg::ADDR_W-1:0] m_tdata, // [31:0] block_address
	output logic [bba_pkg::STATUS_W-1:0] m_tuser // [1:0] status
);
	import bba_pkg::*;

	logic fe_valid;
	logic fe_ready;
	cmd_t fe_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	bba_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cmd_valid(fe_valid),
		.cmd_ready(fe_ready),
		.cmd(fe_cmd)
	);

	bba_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fe_valid),
		.in_ready(fe_ready),
		.in_cmd(fe_cmd),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_cmd(q_cmd)
	);

	bba_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd(q_cmd),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// A result never carries an undefined status code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_BADADDR))
		else $error("result beat with an undefined status");

	// A failed request never returns a block address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("failed request returned a nonzero address");

	// A request that the full queue refuses stays in the front stage unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fe_valid && !fe_ready) |=> (fe_valid && $stable(fe_cmd)))
		else $error("front stage lost a request while the queue was full");

endmodule

### rtl/bba_front.sv
// Front end of the bitmap block allocator: takes request beats and classifies them.
// Depends on bba_pkg.
module bba_front (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [bba_pkg::ADDR_W-1:0] s_tdata, // [31:0] address
	input  logic [0:0] s_tuser,                 // [0] action
	output logic cmd_valid,
	input  logic cmd_ready,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;

	// The stage takes a new beat when it is empty or its content moves on.
	assign s_tready = !valid_s1 || cmd_ready;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !cmd_ready);
		end
	end

	// A free of the null address is settled here and needs no search.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.address <= s_tdata;
			if (s_tuser[0] == 1'b0) begin
				cmd_s1.kind <= CMD_ALLOC;
			end else if (s_tdata == '0) begin
				cmd_s1.kind <= CMD_NULL;
			end else begin
				cmd_s1.kind <= CMD_FREE;
			end
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;

endmodule

### rtl/bba_queue.sv
// Short request queue between the front end and the search engine.
// Depends on bba_pkg.
module bba_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  bba_pkg::cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output bba_pkg::cmd_t out_cmd
);
	import bba_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign in_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_cmd = mem_q[rd_ptr_q];

	// Pointers wrap at the depth; the count tells full from empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

### rtl/bba_engine.sv
// Back end of the bitmap block allocator: configuration registers, used map,
// block search and result register. Depends on bba_pkg.
module bba_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [bba_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0] cfg_wr_data,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  bba_pkg::cmd_t cmd,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [bba_pkg::ADDR_W-1:0] m_tdata, // [31:0] block_address
	output logic [bba_pkg::STATUS_W-1:0] m_tuser // [1:0] status
);
	import bba_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [ADDR_W-1:0] pool_base_q;
	logic [SIZE_W-1:0] block_size_q;
	logic [CNT_W-1:0] block_count_q;
	logic [MAX_BLOCKS-1:0] used_q;
	logic [1:0] state_q;
	cmd_t cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [ADDR_W-1:0] start_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [CNT_W-1:0] live;
	logic is_alloc;
	logic hit;
	logic last;
	logic slot_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			block_size_q <= SIZE_W'(8);
			block_count_q <= CNT_W'(64);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_POOL_BASE: pool_base_q <= cfg_wr_data;
				REG_BLOCK_SIZE: block_size_q <= cfg_wr_data[SIZE_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// A count above the pool size acts as the pool size.
	assign live = (block_count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count_q;

	// One block is examined per cycle; its start address is kept running.
	assign is_alloc = cmd_q.kind == CMD_ALLOC;
	assign hit = is_alloc ? !used_q[idx_q] : (start_q == cmd_q.address);
	assign last = (CNT_W'(idx_q) + CNT_W'(1)) == live;
	assign slot_free = !out_valid_q || m_tready;
	assign cmd_ready = state_q == S_IDLE;

	// Search sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == CMD_NULL || live == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						used_q[idx_q] <= is_alloc;
						state_q <= S_DONE;
					end else if (last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			idx_q <= '0;
			start_q <= pool_base_q;
			res_addr_q <= '0;
			res_status_q <= (cmd.kind == CMD_ALLOC) ? ST_FULL : ST_BADADDR;
		end else if (state_q == S_SCAN) begin
			if (hit) begin
				res_status_q <= ST_OK;
				res_addr_q <= is_alloc ? start_q : '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				start_q <= start_q + ADDR_W'(block_size_q);
			end
		end
	end

	// Output register: holds a finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			out_status_q <= res_status_q;
			out_addr_q <= res_addr_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_addr_q;
	assign m_tuser = out_status_q;

endmodule

### dv/bitmap_block_allocator_tb.sv
// Self-checking testbench for bitmap_block_allocator: directed and random request
// beats under random stalls on both streams, checked against a behavioral pool model.
// Depends on bba_pkg and the bitmap_block_allocator RTL.
module bitmap_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	// Request kinds on s_tuser.
	localparam bit ACT_ALLOC = 1'b0;
	localparam bit ACT_FREE = 1'b1;

	// Register index past the end of the map; writes to it must be ignored.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// One expected reply of the allocator.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0] address;
	} reply_t;

	// Pool model: tracks the used map and configuration and queues expected replies.
	class block_pool_scoreboard;
		logic [ADDR_W-1:0] pool_base;
		logic [SIZE_W-1:0] block_size;
		logic [CNT_W-1:0] block_count;
		bit [MAX_BLOCKS-1:0] used_map;
		reply_t pending_replies[$];
		int errors;

		function new();
			pool_base = '0;
			block_size = 16'd8;
			block_count = 7'd64;
			used_map = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
			case (idx)
				REG_POOL_BASE: pool_base = data;
				REG_BLOCK_SIZE: block_size = data[SIZE_W-1:0];
				REG_BLOCK_COUNT: block_count = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		// Counts above the pool capacity behave as the full pool.
		function int live_count();
			return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
		endfunction

		// Block start wraps around the address space.
		function logic [ADDR_W-1:0] block_start(int idx);
			logic [ADDR_W-1:0] idx_w;
			idx_w = idx;
			return pool_base + idx_w * {{(ADDR_W-SIZE_W){1'b0}}, block_size};
		endfunction

		// Applies one accepted request beat and queues the reply it must produce.
		function void note_request(bit action, logic [ADDR_W-1:0] address);
			reply_t r;
			int n;
			int i;
			r.status = ST_OK;
			r.address = '0;
			n = live_count();
			if (action == ACT_ALLOC) begin
				r.status = ST_FULL;
				for (i = 0; i < n; i++) begin
					if (!used_map[i]) begin
						used_map[i] = 1'b1;
						r.address = block_start(i);
						r.status = ST_OK;
						break;
					end
				end
			end else begin
				// A null address never matches, even when the pool starts at zero.
				r.status = ST_BADADDR;
				if (address != '0) begin
					for (i = 0; i < n; i++) begin
						if (block_start(i) == address) begin
							used_map[i] = 1'b0;
							r.status = ST_OK;
							break;
						end
					end
				end
			end
			pending_replies.push_back(r);
		endfunction

		// Compares one accepted reply beat with the oldest expected reply.
		function void check_response(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] address);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t ERROR: unexpected reply, status %0d address %h",
					$time, status, address);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			if (status !== want.status) begin
				$display("%0t ERROR: status expected %0d, got %0d", $time, want.status, status);
				errors++;
			end
			if (address !== want.address) begin
				$display("%0t ERROR: block address expected %h, got %h",
					$time, want.address, address);
				errors++;
			end
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ADDR_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ADDR_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	block_pool_scoreboard sb = new();

	// Stretches without idling on either side.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_stall_left = 0;

	bitmap_block_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // [31:0] address
		.s_tuser(s_tuser),   // [0] action
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),   // [31:0] block_address
		.m_tuser(m_tuser)    // [1:0] status
	);

	always #5 clk = ~clk;

	// Idle length: mostly none or short, sometimes long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Address for a free request: mostly blocks in use, plus free blocks, null,
	// near misses and arbitrary values.
	function automatic logic [ADDR_W-1:0] pick_free_address();
		int used_idx[$];
		int n;
		int r;
		int i;
		logic [ADDR_W-1:0] a;
		n = sb.live_count();
		r = $urandom_range(0, 99);
		for (i = 0; i < n; i++)
			if (sb.used_map[i])
				used_idx.push_back(i);
		if (r < 50 && used_idx.size() > 0)
			a = sb.block_start(used_idx[$urandom_range(0, used_idx.size() - 1)]);
		else if (r < 70 && n > 0)
			a = sb.block_start($urandom_range(0, n - 1));
		else if (r < 80)
			a = '0;
		else if (r < 90 && n > 0)
			a = sb.block_start($urandom_range(0, n - 1)) + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
		else
			a = $urandom;
		return a;
	endfunction

	// Sends one request beat after a random gap; valid stays high for a following beat.
	task automatic issue(bit action, logic [ADDR_W-1:0] address);
		int n;
		n = tx_steady ? 0 : gap_len();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			s_tuser <= 1'($urandom_range(0, 1));
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= address;
		s_tuser <= action;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(action, address);
	endtask

	// Stops sending and waits for every expected reply.
	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Rewrites all registers once the block is idle; upper data bits carry junk.
	task automatic configure(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size,
			logic [CNT_W-1:0] count, bit spare);
		wait_for_replies();
		repeat (4) @(posedge clk);
		reg_write(REG_POOL_BASE, base);
		reg_write(REG_BLOCK_SIZE, {16'($urandom), size});
		reg_write(REG_BLOCK_COUNT, {25'($urandom), count});
		if (spare)
			reg_write(REG_SPARE, $urandom);
		cfg_wr_en <= 1'b0;
	endtask

	// Reply side: check accepted beats and stall at random.
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready)
				sb.check_response(m_tuser, m_tdata);
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				m_tready <= 1'b0;
			end else begin
				rx_stall_left = rx_steady ? 0 : gap_len();
				m_tready <= (rx_stall_left == 0);
			end
		end
	end

	// Hard limit on the run.
	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Stimulus.
	initial begin
		int phase;
		int items;
		int k;
		int alloc_pct;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: block 0 sits at address zero and cannot be freed.
		issue(ACT_ALLOC, 32'hFFFF_FFFF);
		issue(ACT_ALLOC, 32'h0);
		issue(ACT_ALLOC, $urandom);
		issue(ACT_FREE, 32'h0);
		issue(ACT_FREE, 32'h8);
		issue(ACT_FREE, 32'h8);
		issue(ACT_FREE, 32'h9);
		issue(ACT_FREE, 32'hFFFF_FFFF);
		issue(ACT_ALLOC, 32'h0);

		// Pool wrapping past the top of the address space, already full.
		configure(32'hFFFF_FFF0, 16'd8, 7'd3, 1'b1);
		issue(ACT_ALLOC, 32'h0);
		issue(ACT_FREE, 32'hFFFF_FFF8);
		issue(ACT_ALLOC, 32'h0);
		issue(ACT_FREE, 32'h0);

		// Zero stride with a count above capacity: every block shares one start.
		configure(32'h0000_1000, 16'd0, 7'd127, 1'b0);
		issue(ACT_ALLOC, 32'h0);
		issue(ACT_FREE, 32'h0000_1000);
		issue(ACT_ALLOC, 32'h0);

		// No blocks at all, then a single block with the widest stride.
		configure(32'h0000_2000, 16'hFFFF, 7'd0, 1'b0);
		issue(ACT_ALLOC, 32'h0);
		issue(ACT_FREE, 32'h0000_2000);
		configure(32'h0000_2000, 16'hFFFF, 7'd1, 1'b0);
		issue(ACT_ALLOC, 32'h0);
		issue(ACT_FREE, 32'h0000_2000);
		issue(ACT_ALLOC, 32'h0);
		issue(ACT_FREE, 32'h0001_1FFF);

		// Grown count again: used bits above the old count are still held.
		configure(32'h0000_2000, 16'hFFFF, 7'd64, 1'b0);
		issue(ACT_ALLOC, 32'h0);

		// Random phases, each under its own configuration.
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: configure(32'h0, 16'd8, 7'd64, 1'b0);
				1: configure($urandom, 16'd1, 7'd1, 1'b0);
				2: configure(32'hFFFF_FF00 | $urandom_range(0, 255),
					SIZE_W'($urandom_range(1, 65535)), 7'd127, 1'b1);
				3: configure($urandom, 16'd0, CNT_W'($urandom_range(1, 64)), 1'b0);
				4: configure($urandom, 16'hFFFF, 7'd64, 1'b0);
				5: configure($urandom, SIZE_W'($urandom), 7'd0, 1'b0);
				default: configure($urandom,
					SIZE_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 65535) : $urandom_range(1, 64)),
					CNT_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(65, 127) : $urandom_range(1, 64)),
					1'b0);
			endcase
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			items = (phase == 5) ? 40 : $urandom_range(100, 130);
			alloc_pct = 50;
			for (k = 0; k < items; k++) begin
				if (k % 20 == 0)
					alloc_pct = $urandom_range(15, 85);
				// Let the block drain completely once per phase.
				if (k == items / 2)
					wait_for_replies();
				if ($urandom_range(0, 99) < alloc_pct)
					issue(ACT_ALLOC, $urandom);
				else
					issue(ACT_FREE, pick_free_address());
			end
		end

		wait_for_replies();
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
